// ===== hw/rtl/lbpc_pkg.sv =====
// Shared constants, codes and interface types of the LIFO prime classifier.
package lbpc_pkg;

  // Stack geometry and data width
  localparam int STACK_DEPTH = 1024;
  localparam int VALUE_BITS  = 24;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

  // Fixed field widths of the ports
  localparam int CAP_W       = 11;
  localparam int QUOTA_W     = 20;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int CMP_W       = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  // Reset values of the configuration
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(1024);
  localparam logic [QUOTA_W-1:0] QUOTA_RESET = QUOTA_W'(100000);

  // Trial divisor reaches just past the square root of the largest value
  localparam int DIV_W = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_W  = 2 * DIV_W;
  localparam int BIT_W = $clog2(VALUE_BITS);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSUME  = 2'd1;

  // Write request into the stack memory
  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [VALUE_BITS-1:0] data;
  } ram_wr_t;

  // Read request into the stack memory
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  // Verdict of the primality unit
  typedef struct packed {
    logic done;
    logic prime;
  } pu_res_t;

endpackage

// ===== hw/rtl/lifo_buffer_prime_classifier_unit.sv =====
// Top level: bounded LIFO buffer with pop quota and primality report.
//
// Each accepted item gives one result, shown for a single cycle on out_valid;
// the receiver cannot stall. A push, or any refused item, is answered in the
// cycle after it is accepted and the block can take the next item at once.
// A successful pop first reads the stack memory, then runs the trial-division
// unit: a divisor check, then a bit-serial remainder over all 24 bits of the
// value per divisor, divisors running from 2 while d*d does not exceed the
// value. busy is high while a pop is in progress. Configuration writes are
// taken while busy is low.
module lifo_buffer_prime_classifier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Item channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [lbpc_pkg::VALUE_BITS-1:0]   in_value,
  // Result channel
  output logic                              out_valid,
  output logic [lbpc_pkg::STATUS_W-1:0]     out_status,
  output logic [lbpc_pkg::VALUE_BITS-1:0]   out_popped_value,
  output logic                              out_is_prime_flag,
  output logic [lbpc_pkg::CAP_W-1:0]        out_fill_level,
  output logic [lbpc_pkg::QUOTA_W-1:0]      out_remaining_pops,
  output logic                              out_finished,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lbpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_TEST = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [QUOTA_W-1:0]    quota_r, quota_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic [VALUE_BITS-1:0] popped_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0] out_popped_r, out_popped_nxt;
  logic                  out_prime_r, out_prime_nxt;
  logic [FILL_W-1:0]     out_fill_r, out_fill_nxt;
  logic [QUOTA_W-1:0]    out_quota_r, out_quota_nxt;

  logic                  accept;
  logic                  cfg_fire;
  logic [CMP_W-1:0]      cap_eff;
  logic [FILL_W-1:0]     fill_dec;
  logic                  pu_start;
  logic [VALUE_BITS-1:0] rd_data;
  ram_wr_t               ram_wr;
  ram_rd_t               ram_rd;
  pu_res_t               pu_res;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Capacity clamped to the stack depth
  assign cap_eff  = (CMP_W'(cap_r) > CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH)
                                                          : CMP_W'(cap_r);
  assign fill_dec = fill_r - FILL_W'(1);

  // Item sequencing; pushes and pops never touch memory in the same cycle,
  // and a pop read always comes after the push write of its item
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    quota_nxt      = quota_r;
    ram_wr         = '0;
    ram_rd         = '0;
    pu_start       = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_popped_nxt = '0;
    out_prime_nxt  = 1'b0;
    out_fill_nxt   = fill_r;
    out_quota_nxt  = quota_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          if (quota_r == '0) begin
            out_status_nxt = ST_DONE;
          end else if (in_op == OP_PUSH) begin
            if (CMP_W'(fill_r) >= cap_eff) begin
              out_status_nxt = ST_FULL;
            end else begin
              ram_wr.en    = 1'b1;
              ram_wr.addr  = fill_r[ADDR_W-1:0];
              ram_wr.data  = in_value;
              fill_nxt     = fill_r + FILL_W'(1);
              out_fill_nxt = fill_nxt;
            end
          end else begin
            if (fill_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              // result comes later, after the primality test
              out_valid_nxt = 1'b0;
              ram_rd.en     = 1'b1;
              ram_rd.addr   = fill_dec[ADDR_W-1:0];
              fill_nxt      = fill_dec;
              quota_nxt     = quota_r - QUOTA_W'(1);
              state_nxt     = S_READ;
            end
          end
        end
      end
      S_READ: begin
        pu_start  = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (pu_res.done) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = popped_r;
          out_prime_nxt  = pu_res.prime;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      quota_r     <= QUOTA_RESET;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      quota_r     <= quota_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_CAPACITY: cap_r   <= cfg_data[CAP_W-1:0];
          CFG_CONSUME:  quota_r <= cfg_data[QUOTA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload and popped value
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
    out_prime_r  <= out_prime_nxt;
    out_fill_r   <= out_fill_nxt;
    out_quota_r  <= out_quota_nxt;
    if (state_r == S_READ) begin
      popped_r <= rd_data;
    end
  end

  lbpc_stack_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  lbpc_prime_unit u_prime (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pu_start),
    .value (rd_data),
    .res   (pu_res)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_popped_value   = out_popped_r;
  assign out_is_prime_flag  = out_prime_r;
  assign out_fill_level     = CAP_W'(out_fill_r);
  assign out_remaining_pops = out_quota_r;
  assign out_finished       = (out_quota_r == '0);

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(STACK_DEPTH))
    else $error("fill beyond stack depth");
  a_read_test: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_TEST))
    else $error("memory read not followed by test");
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_popped_r == '0) && !out_prime_r)
    else $error("refused item carries pop data");
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> !out_valid_r)
    else $error("result during memory read");

endmodule

// ===== hw/rtl/lbpc_stack_ram.sv =====
// Stack storage: single-port-write, registered-read synchronous memory.
module lbpc_stack_ram (
  input  logic                           clk,
  input  lbpc_pkg::ram_wr_t              wr,
  input  lbpc_pkg::ram_rd_t              rd,
  output logic [lbpc_pkg::VALUE_BITS-1:0] rd_data
);
  import lbpc_pkg::*;

  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lbpc_prime_unit.sv =====
// Iterative trial-division primality test with a bit-serial remainder unit.
module lbpc_prime_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lbpc_pkg::VALUE_BITS-1:0] value,
  output lbpc_pkg::pu_res_t               res
);
  import lbpc_pkg::*;

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_CHECK = 2'd1;
  localparam logic [1:0] P_DIV   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [DIV_W-1:0]      d_r, d_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic                  done_r, done_nxt;
  logic                  prime_r, prime_nxt;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W:0]        rem_sub;
  logic [DIV_W-1:0]      rem_step;
  logic                  sq_over;

  // One restoring division step: shift in the next dividend bit
  assign rem_sh   = {rem_r, v_r[bit_r]};
  assign rem_sub  = rem_sh - {1'b0, d_r};
  assign rem_step = (rem_sh >= {1'b0, d_r}) ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  // Divisor squared beyond the value: no factor left to find
  assign sq_over  = sq_r > SQ_W'(v_r);

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    prime_nxt = prime_r;
    case (state_r)
      P_IDLE: begin
        if (start) begin
          v_nxt  = value;
          d_nxt  = DIV_W'(2);
          sq_nxt = SQ_W'(4);
          // zero and one are not prime
          if (value < VALUE_BITS'(2)) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
          end else begin
            state_nxt = P_CHECK;
          end
        end
      end
      P_CHECK: begin
        if (sq_over) begin
          done_nxt  = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = P_IDLE;
        end else begin
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(VALUE_BITS - 1);
          state_nxt = P_DIV;
        end
      end
      P_DIV: begin
        rem_nxt = rem_step;
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          if (rem_step == '0) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = P_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_nxt     = d_r + DIV_W'(1);
            sq_nxt    = sq_r + SQ_W'({d_r, 1'b1});
            state_nxt = P_CHECK;
          end
        end
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    prime_r <= prime_nxt;
  end

  assign res.done  = done_r;
  assign res.prime = prime_r;

  // Checks
  a_div_d_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == P_DIV) |-> (d_r >= DIV_W'(2)))
    else $error("trial divisor below two");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == P_IDLE))
    else $error("verdict while still testing");
  a_div_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == P_CHECK) && !sq_over |=> (state_r == P_DIV) && (bit_r == BIT_W'(VALUE_BITS - 1)))
    else $error("division not started from the top bit");

endmodule
